// File: rtl/atl_pkg.sv
// Types, character codes and class tables shared by the assembler token lexer.
package atl_pkg;

	// Longest identifier kept; later characters are dropped and flagged
	localparam int unsigned MAX_IDENT_LEN = 19;
	localparam int unsigned LEN_W = 5;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_IDENT_LEN);

	// Character codes
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;

	// Token codes
	localparam logic [7:0] TOK_NE      = 8'd1;
	localparam logic [7:0] TOK_LE      = 8'd2;
	localparam logic [7:0] TOK_GE      = 8'd3;
	localparam logic [7:0] DOUBLE_MARK = 8'h80;

	// Character class bit maps: bit (c & 15) of entry (c >> 4), ASCII only
	localparam logic [15:0] IDENT_MAP [8] = '{
		16'o000000, 16'o000000, 16'o040000, 16'o001777,
		16'o177776, 16'o103777, 16'o177776, 16'o003777
	};
	localparam logic [15:0] BLANK_MAP [8] = '{
		16'o001000, 16'o000000, 16'o000001, 16'o000000,
		16'o000000, 16'o000000, 16'o000000, 16'o000000
	};

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_IDENT   = 3'd1,
		MODE_HELD    = 3'd2,
		MODE_SLASH   = 3'd3,
		MODE_COMMENT = 3'd4,
		MODE_STAR    = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		KIND_ICHAR = 2'd0,
		KIND_IEND  = 2'd1,
		KIND_TOKEN = 2'd2,
		KIND_EOF   = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_input;
	} in_word_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  value;
		logic [15:0] line_number;
		logic        ident_overflow;
		logic        last;
	} out_word_t;

	function automatic logic is_ident(input logic [7:0] b);
		return !b[7] && IDENT_MAP[b[6:4]][b[3:0]];
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return !b[7] && BLANK_MAP[b[6:4]][b[3:0]];
	endfunction

endpackage

// File: rtl/atl_if.sv
// Valid/ready channel interfaces for source bytes and token words.
interface atl_in_if;
	logic             valid;
	logic             ready;
	atl_pkg::in_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface atl_out_if;
	logic               valid;
	logic               ready;
	atl_pkg::out_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/assembler_token_lexer.sv
// Assembler token lexer: source bytes in, identifier characters and tokens out.
//
//   channel | dir | word                                    | handshake
//   src     | in  | char_in, end_of_input                   | valid/ready
//   tok     | out | kind, value, line_number, overflow, last | valid/ready
//
// A byte is decoded in the cycle it is accepted; its results appear on tok
// in the next cycle from a two-entry output register.
// One byte per cycle while tok drains; a byte giving two results holds src
// low while the second word waits.
// Reset: lexer idle, line count one, output register empty.
module assembler_token_lexer (
	input  logic      clk,
	input  logic      arst_n,
	atl_in_if.sink    src,
	atl_out_if.source tok
);

	// Lexer state
	atl_pkg::mode_t              mode_q, mode_d;
	logic [7:0]                  held_q, held_d;
	logic [atl_pkg::LEN_W-1:0]   len_q, len_d;
	logic [15:0]                 line_q, line_d;
	logic                        ovf_q, ovf_d;

	// Output register: slot 0 is presented, slot 1 waits behind it
	atl_pkg::out_word_t slot0_q, slot1_q;
	logic               v0_q, v1_q;

	logic       acc, take;
	logic [7:0] b;
	logic       eoi;

	// Results of this byte: a leading word, then a word from starting afresh or the end mark
	logic               pre_v, sec_v, use_start;
	atl_pkg::kind_t     pre_kind, sec_kind;
	logic [7:0]         pre_val, sec_val;
	logic               pre_ovf;
	atl_pkg::out_word_t r0, r1;
	logic               r0_v, r1_v;

	assign b   = src.data.char_in;
	assign eoi = src.data.end_of_input;

	assign src.ready = !v1_q && (!v0_q || tok.ready);
	assign acc       = src.valid && src.ready;
	assign take      = v0_q && tok.ready;

	assign tok.valid = v0_q;
	assign tok.data  = slot0_q;

	// Decode the byte against the current mode
	always_comb begin
		mode_d    = mode_q;
		held_d    = held_q;
		len_d     = len_q;
		ovf_d     = ovf_q;
		line_d    = line_q;
		pre_v     = 1'b0;
		pre_kind  = atl_pkg::KIND_TOKEN;
		pre_val   = 8'd0;
		pre_ovf   = 1'b0;
		sec_v     = 1'b0;
		sec_kind  = atl_pkg::KIND_TOKEN;
		sec_val   = 8'd0;
		use_start = 1'b0;

		if (eoi) begin
			// Flush pending work, then mark the end
			case (mode_q)
				atl_pkg::MODE_IDENT: begin
					pre_v    = 1'b1;
					pre_kind = atl_pkg::KIND_IEND;
					pre_ovf  = ovf_q;
				end
				atl_pkg::MODE_HELD: begin
					pre_v   = 1'b1;
					pre_val = held_q;
				end
				atl_pkg::MODE_SLASH: begin
					pre_v   = 1'b1;
					pre_val = atl_pkg::CH_SLASH;
				end
				default: ;
			endcase
			sec_v    = 1'b1;
			sec_kind = atl_pkg::KIND_EOF;
			mode_d   = atl_pkg::MODE_IDLE;
			held_d   = 8'd0;
			len_d    = '0;
			ovf_d    = 1'b0;
		end else begin
			// Count lines, saturating
			if (b == atl_pkg::CH_LF && line_q != 16'hFFFF) begin
				line_d = line_q + 16'd1;
			end
			case (mode_q)
				atl_pkg::MODE_IDENT: begin
					if (atl_pkg::is_ident(b)) begin
						if (len_q < atl_pkg::MAX_LEN) begin
							len_d    = len_q + 1'b1;
							pre_v    = 1'b1;
							pre_kind = atl_pkg::KIND_ICHAR;
							pre_val  = b;
						end else begin
							ovf_d = 1'b1;
						end
					end else begin
						pre_v     = 1'b1;
						pre_kind  = atl_pkg::KIND_IEND;
						pre_ovf   = ovf_q;
						len_d     = '0;
						ovf_d     = 1'b0;
						use_start = 1'b1;
					end
				end
				atl_pkg::MODE_HELD: begin
					pre_v = 1'b1;
					if (b == atl_pkg::CH_EQ && held_q == atl_pkg::CH_BANG) begin
						pre_val = atl_pkg::TOK_NE;
						mode_d  = atl_pkg::MODE_IDLE;
					end else if (b == atl_pkg::CH_EQ && held_q == atl_pkg::CH_LT) begin
						pre_val = atl_pkg::TOK_LE;
						mode_d  = atl_pkg::MODE_IDLE;
					end else if (b == atl_pkg::CH_EQ && held_q == atl_pkg::CH_GT) begin
						pre_val = atl_pkg::TOK_GE;
						mode_d  = atl_pkg::MODE_IDLE;
					end else if (b == held_q) begin
						pre_val = held_q | atl_pkg::DOUBLE_MARK;
						mode_d  = atl_pkg::MODE_IDLE;
					end else begin
						pre_val   = held_q;
						use_start = 1'b1;
					end
				end
				atl_pkg::MODE_SLASH: begin
					if (b == atl_pkg::CH_STAR) begin
						mode_d = atl_pkg::MODE_COMMENT;
					end else begin
						pre_v     = 1'b1;
						pre_val   = atl_pkg::CH_SLASH;
						use_start = 1'b1;
					end
				end
				atl_pkg::MODE_COMMENT: begin
					if (b == atl_pkg::CH_STAR) begin
						mode_d = atl_pkg::MODE_STAR;
					end
				end
				atl_pkg::MODE_STAR: begin
					if (b == atl_pkg::CH_SLASH) begin
						mode_d = atl_pkg::MODE_IDLE;
					end else if (b != atl_pkg::CH_STAR) begin
						mode_d = atl_pkg::MODE_COMMENT;
					end
				end
				default: begin
					use_start = 1'b1;
				end
			endcase

			// Start a new token from this byte
			if (use_start) begin
				if (atl_pkg::is_blank(b)) begin
					mode_d = atl_pkg::MODE_IDLE;
				end else if (atl_pkg::is_ident(b)) begin
					mode_d   = atl_pkg::MODE_IDENT;
					len_d    = atl_pkg::LEN_W'(1);
					ovf_d    = 1'b0;
					sec_v    = 1'b1;
					sec_kind = atl_pkg::KIND_ICHAR;
					sec_val  = b;
				end else if (b == atl_pkg::CH_LF) begin
					mode_d  = atl_pkg::MODE_IDLE;
					sec_v   = 1'b1;
					sec_val = atl_pkg::CH_SEMI;
				end else if (b == atl_pkg::CH_SLASH) begin
					mode_d = atl_pkg::MODE_SLASH;
				end else begin
					mode_d = atl_pkg::MODE_HELD;
					held_d = b;
				end
			end
		end
	end

	// Pack results into at most two words in order
	always_comb begin
		r0.line_number = line_d;
		r1.line_number = line_d;
		r1.kind           = sec_kind;
		r1.value          = sec_val;
		r1.ident_overflow = 1'b0;
		r1.last           = 1'b1;
		if (pre_v) begin
			r0.kind           = pre_kind;
			r0.value          = pre_val;
			r0.ident_overflow = pre_ovf;
			r0.last           = !sec_v;
			r0_v              = 1'b1;
			r1_v              = sec_v;
		end else begin
			r0.kind           = sec_kind;
			r0.value          = sec_val;
			r0.ident_overflow = 1'b0;
			r0.last           = 1'b1;
			r0_v              = sec_v;
			r1_v              = 1'b0;
		end
	end

	// Advance lexer state and output valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= atl_pkg::MODE_IDLE;
			held_q <= 8'd0;
			len_q  <= '0;
			line_q <= 16'd1;
			ovf_q  <= 1'b0;
			v0_q   <= 1'b0;
			v1_q   <= 1'b0;
		end else begin
			if (acc) begin
				mode_q <= mode_d;
				held_q <= held_d;
				len_q  <= len_d;
				line_q <= line_d;
				ovf_q  <= ovf_d;
				v0_q   <= r0_v;
				v1_q   <= r1_v;
			end else if (take) begin
				v0_q <= v1_q;
				v1_q <= 1'b0;
			end
		end
	end

	// Load new words, or shift the waiting word forward
	always_ff @(posedge clk) begin
		if (acc) begin
			slot0_q <= r0;
			slot1_q <= r1;
		end else if (take) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

// File: dv/tb.sv
// Testbench for the assembler token lexer: directed table, random phrases, scoreboard.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_ITEMS = 1700;
	localparam int unsigned HOLD_AT      = 400;
	localparam int unsigned PAUSE_AT     = 800;
	localparam int unsigned HOLD_CYCLES  = 120;
	localparam int unsigned TAIL_CYCLES  = 20;
	localparam int unsigned CYCLE_LIMIT  = 1000000;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct {
		logic [7:0]         b;
		logic               eoi;
		bit                 typed;
		atl_pkg::out_word_t want;
	} table_row_t;

	logic clk;
	logic arst_n;

	atl_in_if  src_if ();
	atl_out_if tok_if ();

	assembler_token_lexer dut (
		.clk   (clk),
		.arst_n(arst_n),
		.src   (src_if),
		.tok   (tok_if)
	);

	// Lexer state as seen by the predictor
	atl_pkg::mode_t              lx_mode;
	logic [7:0]                  lx_held;
	logic [atl_pkg::LEN_W-1:0]   lx_len;
	logic [15:0]                 lx_line;
	logic                        lx_ovf;

	atl_pkg::out_word_t step_words [2];
	int                 step_count;
	atl_pkg::out_word_t tokens_due [$];

	int unsigned errors;
	int unsigned cycles;
	int unsigned items_sent;
	bit          src_steady;
	bit          hold_req;
	string       ident_set =
		"._0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
	table_row_t  directed [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	// Stop a hung run
	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("[assembler_token_lexer] ERROR");
		$finish;
	end

	task automatic report(string what, int unsigned got_v, int unsigned want_v);
		errors++;
		$display("tb: %0t %s mismatch: got %0h want %0h", $realtime, what, got_v, want_v);
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic bit ident_char(logic [7:0] b);
		return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
			(b >= "a" && b <= "z") || b == "_" || b == ".";
	endfunction

	function automatic void emit_word(atl_pkg::kind_t k, logic [7:0] v, logic ovf);
		step_words[step_count] = '{kind: k, value: v, line_number: lx_line,
			ident_overflow: ovf, last: 1'b0};
		step_count++;
	endfunction

	function automatic void close_ident();
		emit_word(atl_pkg::KIND_IEND, 8'h00, lx_ovf);
		lx_len = '0;
		lx_ovf = 1'b0;
		lx_mode = atl_pkg::MODE_IDLE;
	endfunction

	// Take a byte with no token in progress
	function automatic void open_token(logic [7:0] b);
		if (b == CH_TAB || b == CH_SPACE) begin
			lx_mode = atl_pkg::MODE_IDLE;
		end else if (ident_char(b)) begin
			lx_mode = atl_pkg::MODE_IDENT;
			lx_len = atl_pkg::LEN_W'(1);
			lx_ovf = 1'b0;
			emit_word(atl_pkg::KIND_ICHAR, b, 1'b0);
		end else if (b == atl_pkg::CH_LF) begin
			lx_mode = atl_pkg::MODE_IDLE;
			emit_word(atl_pkg::KIND_TOKEN, atl_pkg::CH_SEMI, 1'b0);
		end else if (b == atl_pkg::CH_SLASH) begin
			lx_mode = atl_pkg::MODE_SLASH;
		end else begin
			lx_held = b;
			lx_mode = atl_pkg::MODE_HELD;
		end
	endfunction

	// Advance the predicted lexer by one source word
	function automatic void lex_step(logic [7:0] b, logic eoi);
		step_count = 0;
		if (eoi) begin
			case (lx_mode)
				atl_pkg::MODE_IDENT: close_ident();
				atl_pkg::MODE_HELD:  emit_word(atl_pkg::KIND_TOKEN, lx_held, 1'b0);
				atl_pkg::MODE_SLASH: emit_word(atl_pkg::KIND_TOKEN, atl_pkg::CH_SLASH, 1'b0);
				default: ;
			endcase
			emit_word(atl_pkg::KIND_EOF, 8'h00, 1'b0);
			lx_mode = atl_pkg::MODE_IDLE;
			lx_held = '0;
			lx_len = '0;
			lx_ovf = 1'b0;
		end else begin
			if (b == atl_pkg::CH_LF && lx_line != 16'hFFFF) lx_line++;
			case (lx_mode)
				atl_pkg::MODE_IDENT: begin
					if (ident_char(b)) begin
						if (lx_len < atl_pkg::MAX_LEN) begin
							lx_len++;
							emit_word(atl_pkg::KIND_ICHAR, b, 1'b0);
						end else begin
							lx_ovf = 1'b1;
						end
					end else begin
						close_ident();
						open_token(b);
					end
				end
				atl_pkg::MODE_HELD: begin
					if (b == atl_pkg::CH_EQ && (lx_held == atl_pkg::CH_BANG ||
							lx_held == atl_pkg::CH_LT || lx_held == atl_pkg::CH_GT)) begin
						emit_word(atl_pkg::KIND_TOKEN,
							lx_held == atl_pkg::CH_BANG ? atl_pkg::TOK_NE :
							lx_held == atl_pkg::CH_LT ? atl_pkg::TOK_LE : atl_pkg::TOK_GE,
							1'b0);
						lx_mode = atl_pkg::MODE_IDLE;
					end else if (b == lx_held) begin
						emit_word(atl_pkg::KIND_TOKEN, lx_held | atl_pkg::DOUBLE_MARK, 1'b0);
						lx_mode = atl_pkg::MODE_IDLE;
					end else begin
						emit_word(atl_pkg::KIND_TOKEN, lx_held, 1'b0);
						open_token(b);
					end
				end
				atl_pkg::MODE_SLASH: begin
					if (b == atl_pkg::CH_STAR) begin
						lx_mode = atl_pkg::MODE_COMMENT;
					end else begin
						emit_word(atl_pkg::KIND_TOKEN, atl_pkg::CH_SLASH, 1'b0);
						open_token(b);
					end
				end
				atl_pkg::MODE_COMMENT: begin
					if (b == atl_pkg::CH_STAR) lx_mode = atl_pkg::MODE_STAR;
				end
				atl_pkg::MODE_STAR: begin
					if (b == atl_pkg::CH_SLASH) lx_mode = atl_pkg::MODE_IDLE;
					else if (b != atl_pkg::CH_STAR) lx_mode = atl_pkg::MODE_COMMENT;
				end
				default: open_token(b);
			endcase
		end
		if (step_count > 0) step_words[step_count - 1].last = 1'b1;
	endfunction

	// Offer one source word, wait for it to be taken, then queue its tokens
	task automatic send_byte(logic [7:0] b, logic eoi, bit typed, atl_pkg::out_word_t want);
		int unsigned gap;
		gap = src_steady ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			src_if.valid <= 1'b0;
			src_if.data <= '{char_in: 8'($urandom), end_of_input: 1'($urandom)};
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		src_if.valid <= 1'b1;
		src_if.data <= '{char_in: b, end_of_input: eoi};
		do @(posedge clk); while (!src_if.ready);
		items_sent++;
		lex_step(b, eoi);
		if (typed) begin
			tokens_due.push_back(want);
		end else begin
			for (int i = 0; i < step_count; i++) tokens_due.push_back(step_words[i]);
		end
	endtask

	task automatic feed(logic [7:0] b);
		send_byte(b, 1'b0, 1'b0, '0);
	endtask

	task automatic feed_end();
		send_byte(8'($urandom), 1'b1, 1'b0, '0);
	endtask

	// Hold the source off until every expected token has come out
	task automatic flush_tokens();
		@(negedge clk);
		src_if.valid <= 1'b0;
		while (tokens_due.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_ident();
		return ident_set[$urandom_range(0, ident_set.len() - 1)];
	endfunction

	// Any byte that gets held waiting for a partner
	function automatic logic [7:0] pick_punct();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (ident_char(c) || c == CH_TAB || c == CH_SPACE || c == atl_pkg::CH_LF ||
			c == atl_pkg::CH_SLASH);
		return c;
	endfunction

	function automatic logic [7:0] pick_comment_byte();
		case ($urandom_range(0, 5))
			0, 1: return atl_pkg::CH_STAR;
			2: return atl_pkg::CH_SLASH;
			3: return atl_pkg::CH_LF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic table_row_t known_row(logic [7:0] b, logic eoi, atl_pkg::kind_t k,
			logic [7:0] v, logic [15:0] ln);
		table_row_t row;
		row.b = b;
		row.eoi = eoi;
		row.typed = 1'b1;
		row.want = '{kind: k, value: v, line_number: ln, ident_overflow: 1'b0, last: 1'b1};
		return row;
	endfunction

	function automatic table_row_t plain_row(logic [7:0] b, logic eoi);
		table_row_t row;
		row.b = b;
		row.eoi = eoi;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	// Token sink: random stalls and one long hold-off on request
	initial begin
		int unsigned stall;
		int unsigned hold_left;
		int unsigned phase;
		bit          rx_steady;
		bit          hold_seen;
		stall = 0;
		hold_left = 0;
		phase = 0;
		rx_steady = 1'b0;
		hold_seen = 1'b0;
		tok_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			phase++;
			if (phase % 256 == 0) rx_steady = ($urandom_range(0, 3) == 0);
			if (hold_req && !hold_seen) begin
				hold_seen = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				tok_if.ready <= 1'b0;
				hold_left--;
			end else if (stall > 0) begin
				tok_if.ready <= 1'b0;
				stall--;
			end else begin
				tok_if.ready <= 1'b1;
				stall = rx_steady ? 0 : pick_gap();
			end
		end
	end

	// Sample tokens at the rising edge, compare against the oldest expectation
	always @(posedge clk) begin
		atl_pkg::out_word_t got;
		atl_pkg::out_word_t want;
		bit                 hit;
		hit = arst_n && tok_if.valid && tok_if.ready;
		got = tok_if.data;
		@(negedge clk);
		if (hit) begin
			if (tokens_due.size() == 0) begin
				report("unexpected word", got, 0);
			end else begin
				want = tokens_due.pop_front();
				if (got.kind !== want.kind) report("kind", got.kind, want.kind);
				if (got.value !== want.value) report("value", got.value, want.value);
				if (got.line_number !== want.line_number)
					report("line_number", got.line_number, want.line_number);
				if (got.ident_overflow !== want.ident_overflow)
					report("ident_overflow", got.ident_overflow, want.ident_overflow);
				if (got.last !== want.last) report("last", got.last, want.last);
			end
		end
	end

	// Stimulus: reset, directed table, random phrases
	initial begin
		bit          hold_done;
		bit          pause_done;
		int unsigned len;
		logic [7:0]  c;

		arst_n = 1'b0;
		src_if.valid = 1'b0;
		src_if.data = '0;
		errors = 0;
		items_sent = 0;
		src_steady = 1'b0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		pause_done = 1'b0;

		lx_mode = atl_pkg::MODE_IDLE;
		lx_held = '0;
		lx_len = '0;
		lx_line = 16'd1;
		lx_ovf = 1'b0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed = {
			known_row(atl_pkg::CH_LF, 1'b0, atl_pkg::KIND_TOKEN, atl_pkg::CH_SEMI, 16'd2),
			known_row("A", 1'b0, atl_pkg::KIND_ICHAR, "A", 16'd2),
			plain_row("z", 1'b0),
			known_row(CH_SPACE, 1'b0, atl_pkg::KIND_IEND, 8'h00, 16'd2),
			plain_row(atl_pkg::CH_BANG, 1'b0),
			known_row(atl_pkg::CH_EQ, 1'b0, atl_pkg::KIND_TOKEN, atl_pkg::TOK_NE, 16'd2),
			plain_row(atl_pkg::CH_LT, 1'b0),
			known_row(atl_pkg::CH_EQ, 1'b0, atl_pkg::KIND_TOKEN, atl_pkg::TOK_LE, 16'd2),
			plain_row(atl_pkg::CH_GT, 1'b0),
			known_row(atl_pkg::CH_EQ, 1'b0, atl_pkg::KIND_TOKEN, atl_pkg::TOK_GE, 16'd2),
			plain_row(8'hFF, 1'b0),
			known_row(8'hFF, 1'b0, atl_pkg::KIND_TOKEN, 8'hFF, 16'd2),
			plain_row(8'h00, 1'b0),
			known_row(8'h00, 1'b0, atl_pkg::KIND_TOKEN, atl_pkg::DOUBLE_MARK, 16'd2),
			plain_row(atl_pkg::CH_SLASH, 1'b0),
			plain_row(atl_pkg::CH_SLASH, 1'b0),
			plain_row(atl_pkg::CH_STAR, 1'b0),
			plain_row(atl_pkg::CH_LF, 1'b0),
			plain_row(atl_pkg::CH_STAR, 1'b0),
			plain_row(atl_pkg::CH_STAR, 1'b0),
			plain_row(atl_pkg::CH_SLASH, 1'b0),
			plain_row(CH_TAB, 1'b0),
			plain_row("+", 1'b0),
			plain_row(8'h00, 1'b1),
			plain_row(atl_pkg::CH_SLASH, 1'b0),
			plain_row(atl_pkg::CH_STAR, 1'b0),
			known_row(8'hFF, 1'b1, atl_pkg::KIND_EOF, 8'h00, 16'd3)
		};
		foreach (directed[i])
			send_byte(directed[i].b, directed[i].eoi, directed[i].typed, directed[i].want);

		while (items_sent < directed.size() + RANDOM_ITEMS) begin
			// Let the sink hold off while the source keeps offering words
			if (!hold_done && items_sent > HOLD_AT) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (!pause_done && items_sent > PAUSE_AT) begin
				flush_tokens();
				pause_done = 1'b1;
			end
			src_steady = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 15))
				0, 1, 2, 3: begin
					len = ($urandom_range(0, 6) == 0) ? $urandom_range(17, 26) :
						$urandom_range(1, 8);
					repeat (len) feed(pick_ident());
				end
				4, 5: begin
					case ($urandom_range(0, 2))
						0: feed(atl_pkg::CH_BANG);
						1: feed(atl_pkg::CH_LT);
						default: feed(atl_pkg::CH_GT);
					endcase
					if ($urandom_range(0, 4) == 0) feed(8'($urandom_range(0, 255)));
					else feed(atl_pkg::CH_EQ);
				end
				6, 7: begin
					c = pick_punct();
					feed(c);
					feed(c);
				end
				8, 9: begin
					feed(atl_pkg::CH_SLASH);
					feed(atl_pkg::CH_STAR);
					repeat ($urandom_range(0, 8)) feed(pick_comment_byte());
					if ($urandom_range(0, 5) == 0) begin
						feed_end();
					end else begin
						repeat ($urandom_range(1, 3)) feed(atl_pkg::CH_STAR);
						feed(atl_pkg::CH_SLASH);
					end
				end
				10: begin
					feed(atl_pkg::CH_SLASH);
					feed(8'($urandom_range(0, 255)));
				end
				11: begin
					case ($urandom_range(0, 2))
						0: feed(CH_TAB);
						1: feed(CH_SPACE);
						default: feed(atl_pkg::CH_LF);
					endcase
				end
				12, 13: begin
					repeat ($urandom_range(1, 4)) feed(8'($urandom_range(0, 255)));
				end
				14: feed_end();
				default: begin
					case ($urandom_range(0, 2))
						0: feed(pick_punct());
						1: feed(atl_pkg::CH_SLASH);
						default: feed(pick_ident());
					endcase
					feed_end();
				end
			endcase
		end

		flush_tokens();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) $display("[assembler_token_lexer] OK");
		else $display("[assembler_token_lexer] ERROR");
		$finish;
	end

endmodule
